>>> hdl/positional_ordered_list_core_defines.svh
// assertion macros for the positional ordered list core and its checker
`ifndef POSITIONAL_ORDERED_LIST_CORE_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_CORE_DEFINES_SVH

// same-cycle implication on clk_i, off while rst_ni is low
`define POL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off while rst_ni is low
`define POL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pol_pkg.sv
// shared types and codes of the positional ordered list core
`default_nettype none

package pol_pkg;

  // default list capacity
  localparam int CAPACITY_DEF = 32;

  // field widths
  localparam int REQ_W   = 3;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 3;
  localparam int S_DATA_W = 72;  // position, insert value, search key, zero fill
  localparam int M_DATA_W = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DISPLAY = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SEARCH  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RDISP   = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

  // one result transaction from sequencer to output register
  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/positional_ordered_list_core.sv
// Positional ordered list core: keeps up to CAPACITY signed 32-bit values in order in a
// single-port-read, single-port-write element memory driven by one sequencer. Requests
// come in on s_axis (tuser selects the request), results leave on m_axis through an
// output register, so a new request is taken while the last result still waits. Each
// element moved or inspected costs one memory read and, for moves, one write. Display
// and reverse display wait while m_axis stalls; bad position, full and empty cases
// touch no memory. The block is not ready while a request is in progress. The memory
// needs no clearing pass: only entries below the element count are ever read.
`default_nettype none

module positional_ordered_list_core
  import pol_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request stream
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [5:0] position, [37:6] insert_value, [69:38] search_key, [71:70] zero
  input  wire logic [S_DATA_W-1:0] s_axis_tdata_i,
  // [2:0] req_type
  input  wire logic [REQ_W-1:0]    s_axis_tuser_i,
  // result stream
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [31:0] item_value
  output logic [M_DATA_W-1:0]      m_axis_tdata_o,
  // [2:0] status
  output logic [STAT_W-1:0]        m_axis_tuser_o,
  output logic                     m_axis_tlast_o
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic signed [VAL_W-1:0] rd_data;

  logic res_valid;
  logic res_ready;
  res_t res;

  logic out_valid_q, out_valid_d;
  res_t out_q;

  pol_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pol_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .req_type_i     (s_axis_tuser_i),
    .position_i     (s_axis_tdata_i[5:0]),
    .insert_value_i (s_axis_tdata_i[37:6]),
    .search_key_i   (s_axis_tdata_i[69:38]),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data)
  );

  // output register, refilled when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.value;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;

endmodule

`default_nettype wire

>>> hdl/pol_store.sv
// element store: one write port, one read port with registered data
`default_nettype none

module pol_store
  import pol_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = 5
) (
  input  wire logic                    clk_i,
  input  wire logic                    wr_en_i,
  input  wire logic [AW-1:0]           wr_addr_i,
  input  wire logic signed [VAL_W-1:0] wr_data_i,
  input  wire logic                    rd_en_i,
  input  wire logic [AW-1:0]           rd_addr_i,
  output logic signed [VAL_W-1:0]      rd_data_o
);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data in the cycle after the address
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> hdl/pol_seq.sv
// request sequencer: steps the store port element by element
`default_nettype none

module pol_seq
  import pol_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = 5,
  parameter int CNT_W    = 6
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // request side
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [REQ_W-1:0]        req_type_i,
  input  wire logic [POS_W-1:0]        position_i,
  input  wire logic signed [VAL_W-1:0] insert_value_i,
  input  wire logic signed [VAL_W-1:0] search_key_i,
  // result side
  output logic                         res_valid_o,
  input  wire logic                    res_ready_i,
  output res_t                         res_o,
  // store port
  output logic                         wr_en_o,
  output logic [AW-1:0]                wr_addr_o,
  output logic signed [VAL_W-1:0]      wr_data_o,
  output logic                         rd_en_o,
  output logic [AW-1:0]                rd_addr_o,
  input  wire logic signed [VAL_W-1:0] rd_data_i
);

  // compare width that holds a position and count plus one
  localparam int PW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_CHK  = 4'd1;
  localparam logic [3:0] S_INS_WR   = 4'd2;
  localparam logic [3:0] S_DEL_GONE = 4'd3;
  localparam logic [3:0] S_DEL_CHK  = 4'd4;
  localparam logic [3:0] S_DEL_WR   = 4'd5;
  localparam logic [3:0] S_DISP_RD  = 4'd6;
  localparam logic [3:0] S_DISP_OUT = 4'd7;
  localparam logic [3:0] S_SRCH_RD  = 4'd8;
  localparam logic [3:0] S_SRCH_CMP = 4'd9;
  localparam logic [3:0] S_EMIT     = 4'd10;

  logic [3:0]              state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]        tgt_q, tgt_d;
  logic                    rev_q, rev_d;
  logic signed [VAL_W-1:0] ival_q, ival_d;
  logic signed [VAL_W-1:0] key_q, key_d;
  logic signed [VAL_W-1:0] gone_q, gone_d;
  res_t                    res_q, res_d;

  logic [PW-1:0]    pos_x;
  logic [PW-1:0]    cnt_x;
  logic [PW-1:0]    idx_x;
  logic             disp_last;
  logic [CNT_W-1:0] disp_idx;

  assign pos_x     = PW'(position_i);
  assign cnt_x     = PW'(count_q);
  assign idx_x     = PW'(idx_q);
  assign disp_last = ((idx_x + PW'(1)) == cnt_x);
  assign disp_idx  = rev_q ? (count_q - CNT_W'(1) - idx_q) : idx_q;

  assign in_ready_o = (state_q == S_IDLE);

  // result presented to the output register
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = res_q;
    if (state_q == S_EMIT) begin
      res_valid_o = 1'b1;
    end else if (state_q == S_DISP_OUT) begin
      res_valid_o  = 1'b1;
      res_o.status = ST_OK;
      res_o.value  = rd_data_i;
      res_o.last   = disp_last;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    tgt_d     = tgt_q;
    rev_d     = rev_q;
    ival_d    = ival_q;
    key_d     = key_q;
    gone_d    = gone_q;
    res_d     = res_q;
    wr_en_o   = 1'b0;
    wr_addr_o = idx_q[AW-1:0];
    wr_data_o = rd_data_i;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ival_d     = insert_value_i;
          key_d      = search_key_i;
          res_d.last = 1'b1;
          unique case (req_type_i)
            REQ_INSERT: begin
              res_d.value = '0;
              if ((pos_x == '0) || (pos_x > (cnt_x + PW'(1)))) begin
                res_d.status = ST_BADPOS;
                state_d      = S_EMIT;
              end else if (count_q == CNT_W'(CAPACITY)) begin
                res_d.status = ST_FULL;
                state_d      = S_EMIT;
              end else begin
                idx_d   = count_q;
                tgt_d   = CNT_W'(pos_x - PW'(1));
                state_d = S_INS_CHK;
              end
            end
            REQ_DELETE: begin
              res_d.value = '0;
              if ((pos_x == '0) || (pos_x > cnt_x)) begin
                res_d.status = ST_BADPOS;
                state_d      = S_EMIT;
              end else begin
                idx_d     = CNT_W'(pos_x - PW'(1));
                rd_en_o   = 1'b1;
                rd_addr_o = AW'(pos_x - PW'(1));
                state_d   = S_DEL_GONE;
              end
            end
            REQ_DISPLAY, REQ_RDISP: begin
              rev_d = (req_type_i == REQ_RDISP);
              idx_d = '0;
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
                res_d.value  = '0;
                state_d      = S_EMIT;
              end else begin
                state_d = S_DISP_RD;
              end
            end
            REQ_SEARCH: begin
              idx_d       = '0;
              res_d.value = search_key_i;
              if (count_q == '0) begin
                res_d.status = ST_NOTFOUND;
                state_d      = S_EMIT;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            default: begin
              // unused request codes leave no trace
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // move elements up from the top down to the insert slot
      S_INS_CHK: begin
        if (idx_q > tgt_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(idx_q - CNT_W'(1));
          state_d   = S_INS_WR;
        end else begin
          wr_en_o      = 1'b1;
          wr_addr_o    = tgt_q[AW-1:0];
          wr_data_o    = ival_q;
          count_d      = count_q + CNT_W'(1);
          res_d.status = ST_OK;
          state_d      = S_EMIT;
        end
      end
      S_INS_WR: begin
        wr_en_o = 1'b1;
        idx_d   = idx_q - CNT_W'(1);
        state_d = S_INS_CHK;
      end

      // capture the removed value, then close the gap
      S_DEL_GONE: begin
        gone_d  = rd_data_i;
        state_d = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if ((idx_x + PW'(1)) < cnt_x) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(idx_q + CNT_W'(1));
          state_d   = S_DEL_WR;
        end else begin
          count_d      = count_q - CNT_W'(1);
          res_d.status = ST_OK;
          res_d.value  = gone_q;
          state_d      = S_EMIT;
        end
      end
      S_DEL_WR: begin
        wr_en_o = 1'b1;
        idx_d   = idx_q + CNT_W'(1);
        state_d = S_DEL_CHK;
      end

      // one element per read, held until the output takes it
      S_DISP_RD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = disp_idx[AW-1:0];
        state_d   = S_DISP_OUT;
      end
      S_DISP_OUT: begin
        if (res_ready_i) begin
          if (disp_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_DISP_RD;
          end
        end
      end

      // linear scan, stop on first hit
      S_SRCH_RD: begin
        rd_en_o = 1'b1;
        state_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (rd_data_i == key_q) begin
          res_d.status = ST_FOUND;
          state_d      = S_EMIT;
        end else if ((idx_x + PW'(1)) == cnt_x) begin
          res_d.status = ST_NOTFOUND;
          state_d      = S_EMIT;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_SRCH_RD;
        end
      end

      S_EMIT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    tgt_q  <= tgt_d;
    rev_q  <= rev_d;
    ival_q <= ival_d;
    key_q  <= key_d;
    gone_q <= gone_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

>>> hdl/pol_checker.sv
// port-level checker for the positional ordered list core, with its bind
`default_nettype none
`include "positional_ordered_list_core_defines.svh"

module pol_checker
  import pol_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic [REQ_W-1:0]    s_axis_tuser_i,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [M_DATA_W-1:0] m_axis_tdata_o,
  input wire logic [STAT_W-1:0]   m_axis_tuser_o,
  input wire logic                m_axis_tlast_o
);

  // a stalled result transaction stays offered with the same contents
  `POL_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "result changed while stalled")

  // a valid request keeps the block busy for at least the next cycle
  `POL_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i <= REQ_RDISP), !s_axis_tready_o, "ready right after a request")

  // status codes stay within the defined set
  `POL_ASSERT_IMPL(a_status_range, m_axis_tvalid_o, m_axis_tuser_o <= ST_FULL, "undefined status")

  // only display elements come without last, and they are always ok
  `POL_ASSERT_IMPL(a_nonlast_ok, m_axis_tvalid_o && !m_axis_tlast_o, m_axis_tuser_o == ST_OK, "non-final result with error status")

endmodule

bind positional_ordered_list_core pol_checker u_pol_checker (.*);

`default_nettype wire
